@@ hw/rtl/ilc_pkg.sv @@
// Shared types, character codes and constants of the INI line classifier.
`default_nettype none
package ilc_pkg;

  localparam int unsigned LINE_LEN = 256;
  localparam int unsigned OFF_W    = 9;
  localparam int unsigned CHR_W    = 8;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned OUT_TDATA_W = ((4 * OFF_W + 1 + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - (4 * OFF_W + 1);

  localparam logic [CHR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHR_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [CHR_W-1:0] CH_LBR   = 8'h5B;
  localparam logic [CHR_W-1:0] CH_RBR   = 8'h5D;

  localparam logic [MODE_W-1:0] MODE_ANY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SECT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KEY  = 2'd2;

  typedef enum logic [3:0] {
    PH_LEAD      = 4'd0,
    PH_SECT_SKIP = 4'd1,
    PH_SECT_NAME = 4'd2,
    PH_KEY       = 4'd3,
    PH_VAL_SKIP  = 4'd4,
    PH_VAL       = 4'd5,
    PH_DONE      = 4'd6
  } phase_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_SECTION   = 3'd0,
    KIND_KEY       = 3'd1,
    KIND_EMPTY_KEY = 3'd2,
    KIND_COMMENT   = 3'd3,
    KIND_EMPTY     = 3'd4,
    KIND_GARBAGE   = 3'd5,
    KIND_NONE      = 3'd7
  } kind_e;

  typedef struct packed {
    logic [CHR_W-1:0] chr;
    logic             last;
  } in_word_t;

  typedef struct packed {
    phase_e           phase;
    logic             held;
    kind_e            kind;
    logic [OFF_W-1:0] name_first;
    logic [OFF_W-1:0] name_last;
    logic [OFF_W-1:0] value_first;
    logic [OFF_W-1:0] value_last;
  } line_t;

  localparam line_t LINE_CLEAR = '{
    phase:       PH_LEAD,
    held:        1'b0,
    kind:        KIND_NONE,
    name_first:  '0,
    name_last:   '0,
    value_first: '0,
    value_last:  '0
  };

  typedef struct packed {
    kind_e            kind;
    logic [OFF_W-1:0] name_start;
    logic [OFF_W-1:0] name_end;
    logic [OFF_W-1:0] value_start;
    logic [OFF_W-1:0] value_end;
    logic             overflow;
  } result_t;

endpackage
`default_nettype wire

@@ hw/rtl/ilc_in_reg.sv @@
// Input register stage holding one accepted character word.
`default_nettype none
module ilc_in_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire ilc_pkg::in_word_t word_i,
  output logic                   valid_o,
  input  wire logic              advance_i,
  output ilc_pkg::in_word_t      word_o
);
  import ilc_pkg::*;

  logic     valid_q, valid_d;
  in_word_t word_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule
`default_nettype wire

@@ hw/rtl/ilc_line_core.sv @@
// Per-character line state update and classification at the terminator.
`default_nettype none
module ilc_line_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       fire_i,
  input  wire ilc_pkg::in_word_t          word_i,
  input  wire logic [ilc_pkg::MODE_W-1:0] mode_i,
  output logic                            res_valid_o,
  output ilc_pkg::result_t                res_o
);
  import ilc_pkg::*;

  line_t            line_q, line_d;
  logic [OFF_W-1:0] pos_q, pos_d;
  logic             ovf_q, ovf_d;
  line_t            fin, step_a, step_b;
  logic [OFF_W-1:0] pos_m1;

  function automatic line_t decide(line_t s, kind_e k);
    line_t r;
    r       = s;
    r.kind  = k;
    r.phase = PH_DONE;
    if (k != KIND_SECTION && k != KIND_KEY && k != KIND_EMPTY_KEY) begin
      r.name_first = '0;
      r.name_last  = '0;
    end
    if (k != KIND_KEY && k != KIND_EMPTY_KEY) begin
      r.value_first = '0;
      r.value_last  = '0;
    end
    return r;
  endfunction

  function automatic line_t handle(line_t s, logic [CHR_W-1:0] c, logic [OFF_W-1:0] p,
                                   logic dslash, logic [MODE_W-1:0] m);
    line_t r;
    logic  stop, crlf, blank;
    r     = s;
    stop  = (c == CH_HASH) || dslash;
    crlf  = (c == CH_CR) || (c == CH_LF);
    blank = (c == CH_SPACE) || (c == CH_TAB);
    unique case (s.phase)
      PH_LEAD: begin
        priority if (stop) r = decide(s, KIND_COMMENT);
        else if (c == CH_EQ) r = decide(s, KIND_GARBAGE);
        else if (crlf) r = decide(s, KIND_EMPTY);
        else if (blank) r = s;
        else if (c == CH_LBR) begin
          if (m == MODE_ANY || m == MODE_SECT) r.phase = PH_SECT_SKIP;
          else r = decide(s, KIND_GARBAGE);
        end else begin
          if (m == MODE_ANY || m == MODE_KEY) begin
            r.name_first = p;
            r.name_last  = p + OFF_W'(1);
            r.phase      = PH_KEY;
          end else begin
            r = decide(s, KIND_GARBAGE);
          end
        end
      end
      PH_SECT_SKIP: begin
        if (stop || crlf || c == CH_RBR) r = decide(s, KIND_GARBAGE);
        else if (!blank) begin
          r.name_first = p;
          r.name_last  = p + OFF_W'(1);
          r.phase      = PH_SECT_NAME;
        end
      end
      PH_SECT_NAME: begin
        priority if (stop || crlf) r = decide(s, KIND_GARBAGE);
        else if (c == CH_RBR) r = decide(s, KIND_SECTION);
        else if (!blank) r.name_last = p + OFF_W'(1);
        else r = s;
      end
      PH_KEY: begin
        priority if (stop || crlf || c == CH_LBR || c == CH_RBR) r = decide(s, KIND_GARBAGE);
        else if (c == CH_EQ) r.phase = PH_VAL_SKIP;
        else if (!blank) r.name_last = p + OFF_W'(1);
        else r = s;
      end
      PH_VAL_SKIP: begin
        if (stop) r = decide(s, KIND_GARBAGE);
        else if (!blank) begin
          r.value_first = p;
          r.value_last  = p + OFF_W'(1);
          r.phase       = PH_VAL;
        end
      end
      PH_VAL: begin
        if (!blank) r.value_last = p + OFF_W'(1);
      end
      default: r = s;
    endcase
    return r;
  endfunction

  // Close the line content at p: flush a held slash, then settle the kind.
  function automatic line_t finish(line_t s, logic [OFF_W-1:0] p, logic [MODE_W-1:0] m);
    line_t r;
    r = s;
    if (s.held) begin
      r.held = 1'b0;
      r      = handle(r, CH_SLASH, p - OFF_W'(1), 1'b0, m);
    end
    unique case (r.phase)
      PH_DONE: r = r;
      PH_VAL_SKIP: begin
        r.value_first = p;
        r.value_last  = p;
        r = decide(r, KIND_EMPTY_KEY);
      end
      PH_VAL: r = decide(r, KIND_KEY);
      default: r = decide(r, KIND_GARBAGE);
    endcase
    return r;
  endfunction

  assign pos_m1 = pos_q - OFF_W'(1);
  assign fin    = finish(line_q, pos_q, mode_i);

  always_comb begin
    step_a = line_q;
    if (line_q.held) begin
      step_a.held = 1'b0;
      step_a = handle(step_a, CH_SLASH, pos_m1, word_i.chr == CH_SLASH, mode_i);
    end
    step_b = step_a;
    if (step_a.phase != PH_DONE) begin
      if (word_i.chr == CH_SLASH) step_b.held = 1'b1;
      else step_b = handle(step_a, word_i.chr, pos_q, 1'b0, mode_i);
    end
  end

  always_comb begin
    line_d = line_q;
    pos_d  = pos_q;
    ovf_d  = ovf_q;
    if (fire_i) begin
      if (word_i.last) begin
        line_d = LINE_CLEAR;
        pos_d  = '0;
        ovf_d  = 1'b0;
      end else if (pos_q >= OFF_W'(LINE_LEN)) begin
        ovf_d = 1'b1;
      end else begin
        if (line_q.phase != PH_DONE) begin
          if (word_i.chr == CH_NUL) line_d = finish(line_q, pos_q, mode_i);
          else line_d = step_b;
        end
        pos_d = pos_q + OFF_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= LINE_CLEAR;
      pos_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      line_q <= line_d;
      pos_q  <= pos_d;
      ovf_q  <= ovf_d;
    end
  end

  assign res_valid_o       = fire_i && word_i.last;
  assign res_o.kind        = fin.kind;
  assign res_o.name_start  = fin.name_first;
  assign res_o.name_end    = fin.name_last;
  assign res_o.value_start = fin.value_first;
  assign res_o.value_end   = fin.value_last;
  assign res_o.overflow    = ovf_q;

endmodule
`default_nettype wire

@@ hw/rtl/ilc_out_reg.sv @@
// Result register driving the output stream.
`default_nettype none
module ilc_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire ilc_pkg::result_t res_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output ilc_pkg::result_t      res_o
);
  import ilc_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

@@ hw/rtl/ini_line_classifier.sv @@
// Top level of the INI line classifier.
// Result path: input register, combinational line core, result register.
// Throughput: one word per cycle unless a terminator waits for the result register.
// A terminator waits in the input register only while the result register is full.
// Reset: line state cleared, mode register returns to 0 (any kind accepted).
`default_nettype none
module ini_line_classifier (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ilc_pkg::MODE_W-1:0] cfg_wdata_i,   // wanted_kind
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [7:0]                 s_axis_tdata,  // [7:0] char_in
  input  wire logic                       s_axis_tlast,  // line_end
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // [8:0] name_start, [17:9] name_end, [26:18] value_start, [35:27] value_end,
  // [36] overflow, [39:37] zero
  output logic [ilc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [ilc_pkg::KIND_W-1:0]      m_axis_tuser   // [2:0] line_kind
);
  import ilc_pkg::*;

  logic [MODE_W-1:0] mode_q;
  in_word_t          in_word, s1_word;
  logic              s1_valid, advance, out_free, res_valid;
  result_t           res, out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ANY;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  assign in_word.chr  = s_axis_tdata;
  assign in_word.last = s_axis_tlast;
  assign advance      = s1_valid && (!s1_word.last || out_free);

  ilc_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .word_i    (in_word),
    .valid_o   (s1_valid),
    .advance_i (advance),
    .word_o    (s1_word)
  );

  ilc_line_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .word_i      (s1_word),
    .mode_i      (mode_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ilc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_res.overflow, out_res.value_end,
                         out_res.value_start, out_res.name_end, out_res.name_start};
  assign m_axis_tuser = out_res.kind;

endmodule
`default_nettype wire

@@ dv/tb_ini_line_classifier.sv @@
// Testbench for the INI line classifier: random and directed lines, a line predictor, a scoreboard.
`default_nettype none
module tb_ini_line_classifier;
  import ilc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int TIMEOUT     = 400000;

  typedef logic [CHR_W-1:0] chars_t[$];

  // Predictor of the line state plus the queue of expected result words.
  class line_scoreboard;
    logic [MODE_W-1:0] mode;
    phase_e            ph;
    int                pos;
    logic              held;
    kind_e             kind;
    logic [OFF_W-1:0]  nf, nl, vf, vl;
    logic              ovf;
    result_t           expected_lines[$];
    int                errors;
    int                lines_checked;
    int                overflow_lines;
    int                kind_seen[8];

    function new();
      mode = MODE_ANY;
      errors = 0;
      lines_checked = 0;
      overflow_lines = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      reset_line();
    endfunction

    function void reset_line();
      ph = PH_LEAD;
      pos = 0;
      held = 1'b0;
      kind = KIND_NONE;
      nf = '0;
      nl = '0;
      vf = '0;
      vl = '0;
      ovf = 1'b0;
    endfunction

    function bit is_space(logic [CHR_W-1:0] c);
      return c == CH_SPACE || c == CH_TAB;
    endfunction

    function void decide(kind_e k);
      kind = k;
      ph = PH_DONE;
      if (k != KIND_SECTION && k != KIND_KEY && k != KIND_EMPTY_KEY) begin
        nf = '0;
        nl = '0;
      end
      if (k != KIND_KEY && k != KIND_EMPTY_KEY) begin
        vf = '0;
        vl = '0;
      end
    endfunction

    function void handle_char(logic [CHR_W-1:0] c, int p, bit dslash);
      bit stop;
      bit crlf;
      stop = (c == CH_HASH) || dslash;
      crlf = (c == CH_CR) || (c == CH_LF);
      case (ph)
        PH_LEAD: begin
          if (stop) decide(KIND_COMMENT);
          else if (c == CH_EQ) decide(KIND_GARBAGE);
          else if (crlf) decide(KIND_EMPTY);
          else if (is_space(c)) begin
          end else if (c == CH_LBR) begin
            if (mode == MODE_ANY || mode == MODE_SECT) ph = PH_SECT_SKIP;
            else decide(KIND_GARBAGE);
          end else begin
            if (mode == MODE_ANY || mode == MODE_KEY) begin
              nf = OFF_W'(p);
              nl = OFF_W'(p + 1);
              ph = PH_KEY;
            end else begin
              decide(KIND_GARBAGE);
            end
          end
        end
        PH_SECT_SKIP: begin
          if (stop || crlf || c == CH_RBR) decide(KIND_GARBAGE);
          else if (!is_space(c)) begin
            nf = OFF_W'(p);
            nl = OFF_W'(p + 1);
            ph = PH_SECT_NAME;
          end
        end
        PH_SECT_NAME: begin
          if (stop || crlf) decide(KIND_GARBAGE);
          else if (c == CH_RBR) decide(KIND_SECTION);
          else if (!is_space(c)) nl = OFF_W'(p + 1);
        end
        PH_KEY: begin
          if (stop || crlf || c == CH_LBR || c == CH_RBR) decide(KIND_GARBAGE);
          else if (c == CH_EQ) ph = PH_VAL_SKIP;
          else if (!is_space(c)) nl = OFF_W'(p + 1);
        end
        PH_VAL_SKIP: begin
          if (stop) decide(KIND_GARBAGE);
          else if (!is_space(c)) begin
            vf = OFF_W'(p);
            vl = OFF_W'(p + 1);
            ph = PH_VAL;
          end
        end
        PH_VAL: begin
          if (!is_space(c)) vl = OFF_W'(p + 1);
        end
        default: begin
        end
      endcase
    endfunction

    function void close_line(int endpos);
      if (held) begin
        held = 1'b0;
        handle_char(CH_SLASH, endpos - 1, 1'b0);
      end
      if (ph == PH_DONE) return;
      if (ph == PH_VAL_SKIP) begin
        vf = OFF_W'(endpos);
        vl = OFF_W'(endpos);
        decide(KIND_EMPTY_KEY);
      end else if (ph == PH_VAL) begin
        decide(KIND_KEY);
      end else begin
        decide(KIND_GARBAGE);
      end
    endfunction

    function void note_word(logic [CHR_W-1:0] c, logic last);
      result_t r;
      if (!last) begin
        if (pos >= LINE_LEN) begin
          ovf = 1'b1;
          return;
        end
        if (ph != PH_DONE) begin
          if (c == CH_NUL) begin
            close_line(pos);
          end else begin
            if (held) begin
              held = 1'b0;
              handle_char(CH_SLASH, pos - 1, c == CH_SLASH);
            end
            if (ph != PH_DONE) begin
              if (c == CH_SLASH) held = 1'b1;
              else handle_char(c, pos, 1'b0);
            end
          end
        end
        pos++;
      end else begin
        close_line(pos);
        r.kind = kind;
        r.name_start = nf;
        r.name_end = nl;
        r.value_start = vf;
        r.value_end = vl;
        r.overflow = ovf;
        expected_lines.push_back(r);
        reset_line();
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      lines_checked++;
      if (expected_lines.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: kind %0d", got.kind);
        return;
      end
      want = expected_lines.pop_front();
      kind_seen[want.kind]++;
      if (want.overflow) overflow_lines++;
      if (got.kind !== want.kind || got.name_start !== want.name_start ||
          got.name_end !== want.name_end || got.value_start !== want.value_start ||
          got.value_end !== want.value_end || got.overflow !== want.overflow) begin
        errors++;
        if (errors <= 10) begin
          $display("line %0d mismatch: expected kind %0d name %0d..%0d value %0d..%0d ovf %0d",
                   lines_checked, want.kind, want.name_start, want.name_end,
                   want.value_start, want.value_end, want.overflow);
          $display("                    actual kind %0d name %0d..%0d value %0d..%0d ovf %0d",
                   got.kind, got.name_start, got.name_end,
                   got.value_start, got.value_end, got.overflow);
        end
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [MODE_W-1:0]      cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]      m_axis_tuser;

  line_scoreboard sb = new();
  bit src_idle_on;
  bit snk_idle_on;
  bit hold_req;
  int words_sent;

  ini_line_classifier DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #TIMEOUT;
    $display("Verification failed");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind        = kind_e'(m_axis_tuser);
      got.name_start  = m_axis_tdata[OFF_W-1:0];
      got.name_end    = m_axis_tdata[2*OFF_W-1:OFF_W];
      got.value_start = m_axis_tdata[3*OFF_W-1:2*OFF_W];
      got.value_end   = m_axis_tdata[4*OFF_W-1:3*OFF_W];
      got.overflow    = m_axis_tdata[4*OFF_W];
      sb.check_word(got);
    end
  end

  task automatic send_word(input logic [7:0] c, input logic last);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_word(c, last);
    words_sent++;
  endtask

  task automatic send_line(input chars_t q);
    foreach (q[i]) send_word(q[i], 1'b0);
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    chars_t q;
    foreach (s[i]) q.push_back(s[i]);
    send_line(q);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_lines.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    sb.mode = m;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] special_char();
    case ($urandom_range(0, 9))
      0: return CH_HASH;
      1: return CH_SLASH;
      2: return CH_EQ;
      3: return CH_LBR;
      4: return CH_RBR;
      5: return CH_SPACE;
      6: return CH_TAB;
      7: return CH_CR;
      8: return CH_LF;
      default: return CH_NUL;
    endcase
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 4) == 0) c = 8'($urandom_range(128, 255));
      else c = 8'($urandom_range(33, 126));
    end while (c == CH_HASH || c == CH_SLASH || c == CH_EQ || c == CH_LBR || c == CH_RBR);
    return c;
  endfunction

  function automatic void put_blanks(ref chars_t q, input int maxn);
    repeat ($urandom_range(0, maxn)) q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endfunction

  function automatic void put_name(ref chars_t q, input int maxn);
    int n;
    n = $urandom_range(1, maxn);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 5) == 0) put_blanks(q, 2);
      q.push_back(name_char());
    end
  endfunction

  function automatic void put_junk(ref chars_t q, input int maxn);
    repeat ($urandom_range(0, maxn))
      q.push_back($urandom_range(0, 1) ? special_char() : 8'($urandom_range(0, 255)));
  endfunction

  function automatic chars_t random_line();
    chars_t q;
    int sel;
    sel = $urandom_range(0, 19);
    put_blanks(q, 3);
    if (sel <= 5 || sel >= 16) begin
      put_name(q, 8);
      put_blanks(q, 2);
      q.push_back(CH_EQ);
      put_blanks(q, 2);
      if ($urandom_range(0, 4) != 0) begin
        put_name(q, 8);
        if ($urandom_range(0, 3) == 0) begin
          q.push_back(special_char());
          put_name(q, 3);
        end
      end
      put_blanks(q, 3);
    end else if (sel <= 9) begin
      q.push_back(CH_LBR);
      put_blanks(q, 2);
      put_name(q, 8);
      put_blanks(q, 2);
      q.push_back(CH_RBR);
      if ($urandom_range(0, 2) == 0) put_junk(q, 4);
    end else if (sel <= 11) begin
      q.push_back(CH_SLASH);
      q.push_back($urandom_range(0, 1) ? CH_SLASH : CH_HASH);
      if ($urandom_range(0, 1) == 0) q[q.size()-2] = CH_HASH;
      put_junk(q, 6);
    end else if (sel == 12) begin
      q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
      put_junk(q, 3);
    end else begin
      put_junk(q, 12);
    end
    // broken variants of well-formed lines
    if (sel >= 16 && q.size() > 0) begin
      if ($urandom_range(0, 1) == 0) q[$urandom_range(0, q.size() - 1)] = special_char();
      else q.insert($urandom_range(0, q.size()), special_char());
    end
    if ($urandom_range(0, 79) == 0) begin
      repeat ($urandom_range(240, 300))
        q.push_back($urandom_range(0, 7) == 0 ? CH_SPACE : name_char());
    end
    return q;
  endfunction

  task automatic run_lines(input int budget, input bit idling, input bit with_hold);
    int first;
    bit held_off;
    first = words_sent;
    held_off = 1'b0;
    while (words_sent - first < budget) begin
      src_idle_on = idling && $urandom_range(0, 5) != 0;
      snk_idle_on = idling && $urandom_range(0, 5) != 0;
      if (with_hold && !held_off && words_sent - first >= budget / 3) begin
        hold_req = 1'b1;
        held_off = 1'b1;
      end
      send_line(random_line());
    end
  endtask

  initial begin
    chars_t q;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= MODE_ANY;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    hold_req = 1'b0;
    words_sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("");
    send_text(" \t ");
    send_text("\n x");
    q = '{CH_TAB, CH_CR, 8'h41};
    send_line(q);
    send_text("[sec]");
    send_text(" [ a b ]tail=#");
    send_text("[]");
    send_text("[ab");
    send_text("[#]");
    send_text("key = val  ");
    send_text("k=");
    send_text("k = \t");
    send_text("# note");
    send_text("  //c");
    send_text("/a=b");
    send_text("a=/");
    send_text("a/");
    send_text("=x");
    send_text("a b=c#d//[]=");
    send_text("k[=v");
    q = '{8'h61, CH_EQ, 8'h62, CH_NUL, 8'h7A, CH_HASH};
    send_line(q);
    q = '{CH_SLASH, CH_NUL, 8'h61};
    send_line(q);
    q = '{8'hFF, 8'h80, CH_EQ, 8'h7F};
    send_line(q);
    q = '{8'h6B, CH_EQ};
    repeat (298) q.push_back(8'h76);
    send_line(q);
    q = {};
    repeat (LINE_LEN) q.push_back(8'h6B);
    send_line(q);

    drain();
    run_lines(380, 1'b1, 1'b1);
    write_mode(MODE_SECT);
    run_lines(130, 1'b1, 1'b0);
    write_mode(MODE_KEY);
    run_lines(130, 1'b1, 1'b0);
    write_mode(MODE_NONE);
    run_lines(80, 1'b1, 1'b0);
    write_mode(MODE_ANY);
    run_lines(100, 1'b0, 1'b0);
    drain();

    $display("Sent %0d words, checked %0d lines under all four mode settings, %0d overflowed.",
             words_sent, sb.lines_checked, sb.overflow_lines);
    $display("Lines by kind: section %0d, key %0d, empty key %0d, comment %0d, empty %0d,",
             sb.kind_seen[KIND_SECTION], sb.kind_seen[KIND_KEY], sb.kind_seen[KIND_EMPTY_KEY],
             sb.kind_seen[KIND_COMMENT], sb.kind_seen[KIND_EMPTY]);
    $display("  garbage %0d", sb.kind_seen[KIND_GARBAGE]);
    if (sb.errors == 0 && sb.expected_lines.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Mismatches: %0d", sb.errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
